/* src/touch_wheel_position_defines.svh */
// Assertion macros used by the checker file of the wheel position block.
`ifndef TOUCH_WHEEL_POSITION_DEFINES_SVH
`define TOUCH_WHEEL_POSITION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TWP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("touch wheel position: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TWP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("touch wheel position: assertion failed");

// Next-cycle implication that is checked through reset as well.
`define TWP_ASSERT_RST_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("touch wheel position: assertion failed");

`endif

/* src/twp_pkg.sv */
package twp_pkg;

   localparam int NUM_CH  = 4;
   localparam int CNT_W   = 16;
   localparam int NUM_W   = 16;
   localparam int DEN_W   = 17;
   localparam int QUOT_W  = 9;
   localparam int PROD_W  = 25;
   localparam int SEC_W   = 10;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 16;

   localparam logic [IDX_W-1:0] REG_THRESHOLD_CH0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_THRESHOLD_CH1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_THRESHOLD_CH2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_THRESHOLD_CH3 = 3'd3;
   localparam logic [IDX_W-1:0] REG_MIN_DIFF      = 3'd4;
   localparam logic [IDX_W-1:0] REG_RESOLUTION    = 3'd5;
   localparam logic [IDX_W-1:0] REG_TRIM_OFFSET   = 3'd6;
   localparam logic [IDX_W-1:0] REG_SECTOR_STEP   = 3'd7;

   localparam logic [15:0] MIN_DIFF_RESET    = 16'd50;
   localparam logic [7:0]  RESOLUTION_RESET  = 8'd90;
   localparam logic [7:0]  TRIM_OFFSET_RESET = 8'd12;
   localparam logic [7:0]  SECTOR_STEP_RESET = 8'd64;
   localparam logic [7:0]  POSITION_MAX      = 8'd255;

   typedef struct packed {
      logic [NUM_CH-1:0][CNT_W-1:0] threshold;
      logic [15:0]                  min_diff;
      logic [7:0]                   resolution;
      logic [7:0]                   trim_offset;
      logic [7:0]                   sector_step;
   } twp_cfg_type;

   // One classified scan as it waits in the queue.
   typedef struct packed {
      logic             ok;
      logic [1:0]       seg;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] num;
   } twp_item_type;

endpackage

/* src/touch_wheel_position.sv */
// Channel  Direction  Beat contents (lowest bit first)
// req      in         tdata: count_ch0..count_ch3 (16 b each); tuser: wheel_touched
// rsp      out        tdata: position (8 b); tuser: position_valid
// csr      in         write enable, index 0..7, 16-bit data; no read-back
//
// One scan beat is taken and one result beat leaves every cycle while rsp is not
// stalled; an accepted req beat passes the front register, the queue, the
// multiply stage, nine one-bit divide stages and the output register.
// Synchronous reset loads the register defaults and empties all stages.
// A stalled rsp freezes the back pipeline once its output register holds a beat;
// the queue and the front register then fill with QUEUE_DEPTH + 1 beats and
// req_tready falls.
module touch_wheel_position #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // count_ch0 [15:0], count_ch1 [31:16], count_ch2 [47:32], count_ch3 [63:48]
   input  logic [63:0] req_tdata,
   // wheel_touched [0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // position [7:0]
   output logic [7:0]  rsp_tdata,
   // position_valid [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [twp_pkg::IDX_W-1:0]  csr_index,
   input  logic [twp_pkg::DATA_W-1:0] csr_wdata
);

   twp_pkg::twp_cfg_type  cfg_ff;
   twp_pkg::twp_cfg_type  cfg_in;
   twp_pkg::twp_item_type front_item;
   twp_pkg::twp_item_type queue_item;
   logic [twp_pkg::NUM_CH-1:0][twp_pkg::CNT_W-1:0] counts;
   logic front_valid, queue_ready;
   logic queue_valid, queue_pop;

   // Configuration registers. The user must write them only while the block is
   // idle; the block does not enforce this. The pipeline reads them directly.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            twp_pkg::REG_THRESHOLD_CH0: cfg_in.threshold[0] = csr_wdata;
            twp_pkg::REG_THRESHOLD_CH1: cfg_in.threshold[1] = csr_wdata;
            twp_pkg::REG_THRESHOLD_CH2: cfg_in.threshold[2] = csr_wdata;
            twp_pkg::REG_THRESHOLD_CH3: cfg_in.threshold[3] = csr_wdata;
            twp_pkg::REG_MIN_DIFF:      cfg_in.min_diff     = csr_wdata;
            twp_pkg::REG_RESOLUTION:    cfg_in.resolution   = csr_wdata[7:0];
            twp_pkg::REG_TRIM_OFFSET:   cfg_in.trim_offset  = csr_wdata[7:0];
            twp_pkg::REG_SECTOR_STEP:   cfg_in.sector_step  = csr_wdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= '0;
         cfg_ff.min_diff    <= twp_pkg::MIN_DIFF_RESET;
         cfg_ff.resolution  <= twp_pkg::RESOLUTION_RESET;
         cfg_ff.trim_offset <= twp_pkg::TRIM_OFFSET_RESET;
         cfg_ff.sector_step <= twp_pkg::SECTOR_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign counts = req_tdata;

   // The front finds the peak electrode and the segment, then registers the
   // numerator and denominator for the queue.
   twp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_count   (counts),
      .in_touched (req_tuser[0]),
      .out_valid  (front_valid),
      .out_ready  (queue_ready),
      .out_item   (front_item)
   );

   twp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_item   (queue_item)
   );

   // The back multiplies, divides a bit per stage, trims, adds the sector
   // offset and saturates into the output register.
   twp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (queue_valid),
      .in_pop             (queue_pop),
      .in_item            (queue_item),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_position       (rsp_tdata),
      .out_position_valid (rsp_tuser[0])
   );

endmodule

/* src/twp_front.sv */
module twp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  twp_pkg::twp_cfg_type          cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [twp_pkg::NUM_CH-1:0][twp_pkg::CNT_W-1:0] in_count,
   input  logic                          in_touched,
   output logic                          out_valid,
   input  logic                          out_ready,
   output twp_pkg::twp_item_type         out_item
);

   logic [twp_pkg::CNT_W-1:0] d [twp_pkg::NUM_CH];
   logic [twp_pkg::CNT_W-1:0] peak_val;
   logic [1:0]                peak;
   twp_pkg::twp_item_type     item_in;
   twp_pkg::twp_item_type     item_ff;
   logic                      valid_in;
   logic                      valid_ff;
   logic                      take;

   function automatic logic [twp_pkg::DEN_W-1:0] add17(input logic [15:0] a,
                                                     input logic [15:0] b);
      add17 = {1'b0, a} + {1'b0, b};
   endfunction

   always_comb begin
      for (int k = 0; k < twp_pkg::NUM_CH; k++) begin
         d[k] = (in_count[k] < cfg.threshold[k]) ? (cfg.threshold[k] - in_count[k]) : '0;
      end
      // Strict compare keeps the lowest electrode on a tie.
      peak_val = d[0];
      peak     = 2'd0;
      for (int k = 1; k < twp_pkg::NUM_CH; k++) begin
         if (d[k] > peak_val) begin
            peak_val = d[k];
            peak     = 2'(k);
         end
      end
      item_in.ok = in_touched && (peak_val >= cfg.min_diff);
      case (peak)
         2'd0: begin
            if (d[1] > d[3]) begin
               item_in.num = d[1]; item_in.den = add17(d[0], d[1]); item_in.seg = 2'd0;
            end else begin
               item_in.num = d[0]; item_in.den = add17(d[3], d[0]); item_in.seg = 2'd3;
            end
         end
         2'd1: begin
            if (d[0] > d[2]) begin
               item_in.num = d[1]; item_in.den = add17(d[0], d[1]); item_in.seg = 2'd0;
            end else begin
               item_in.num = d[2]; item_in.den = add17(d[1], d[2]); item_in.seg = 2'd1;
            end
         end
         2'd2: begin
            if (d[1] > d[3]) begin
               item_in.num = d[2]; item_in.den = add17(d[1], d[2]); item_in.seg = 2'd1;
            end else begin
               item_in.num = d[3]; item_in.den = add17(d[2], d[3]); item_in.seg = 2'd2;
            end
         end
         default: begin
            if (d[2] > d[0]) begin
               item_in.num = d[3]; item_in.den = add17(d[2], d[3]); item_in.seg = 2'd2;
            end else begin
               item_in.num = d[0]; item_in.den = add17(d[3], d[0]); item_in.seg = 2'd3;
            end
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* src/twp_fifo.sv */
module twp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  twp_pkg::twp_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop,
   output twp_pkg::twp_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   twp_pkg::twp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/twp_back.sv */
module twp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  twp_pkg::twp_cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_pop,
   input  twp_pkg::twp_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_position,
   output logic                  out_position_valid
);

   localparam int NDIV  = twp_pkg::QUOT_W;
   localparam int REM_W = twp_pkg::PROD_W;
   localparam int QW    = twp_pkg::QUOT_W;

   logic                       adv;
   logic [NDIV:0]              v_ff;
   logic [REM_W-1:0]           rem_ff  [NDIV+1];
   logic [twp_pkg::DEN_W-1:0]  den_ff  [NDIV+1];
   logic [QW-1:0]              q_ff    [NDIV+1];
   logic [twp_pkg::SEC_W-1:0]  sec_ff  [NDIV+1];
   logic                       ok_ff   [NDIV+1];
   logic                       dz_ff   [NDIV+1];

   logic [QW-1:0]              mult_in;
   logic [REM_W-1:0]           prod_in;
   logic [twp_pkg::SEC_W-1:0]  sec_in;

   logic [QW-1:0]              quot;
   logic [QW-1:0]              trimmed;
   logic [10:0]                sum;
   logic [7:0]                 pos_in;
   logic                       valid_ff;
   logic [7:0]                 pos_ff;
   logic                       pv_ff;

   // The whole back pipeline moves together whenever the output slot is free.
   assign adv    = !valid_ff || out_ready;
   assign in_pop = adv && in_valid;

   assign mult_in = {1'b0, cfg.resolution} + QW'(1);
   assign prod_in = REM_W'(mult_in) * REM_W'(in_item.num);
   assign sec_in  = twp_pkg::SEC_W'(cfg.sector_step) * twp_pkg::SEC_W'(in_item.seg);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NDIV-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= prod_in;
         den_ff[0] <= in_item.den;
         q_ff[0]   <= '0;
         sec_ff[0] <= sec_in;
         ok_ff[0]  <= in_item.ok;
         dz_ff[0]  <= (in_item.den == '0);
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 1; k <= NDIV; k++) begin : g_div
      localparam int B = QW - k;
      logic [REM_W-1:0] shifted;
      logic             ge;
      logic [REM_W-1:0] rem_in;
      logic [QW-1:0]    q_in;

      assign shifted = REM_W'(den_ff[k-1]) << B;
      assign ge      = (rem_ff[k-1] >= shifted);
      assign rem_in  = ge ? (rem_ff[k-1] - shifted) : rem_ff[k-1];
      assign q_in    = q_ff[k-1] | (ge ? (QW'(1) << B) : '0);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in;
            sec_ff[k] <= sec_ff[k-1];
            ok_ff[k]  <= ok_ff[k-1];
            dz_ff[k]  <= dz_ff[k-1];
         end
      end
   end

   // A zero denominator only comes with a zero numerator; the quotient is zero.
   assign quot    = dz_ff[NDIV] ? '0 : q_ff[NDIV];
   assign trimmed = (quot >= {1'b0, cfg.trim_offset}) ? (quot - {1'b0, cfg.trim_offset}) : '0;
   assign sum     = 11'(trimmed) + 11'(sec_ff[NDIV]);
   assign pos_in  = !ok_ff[NDIV] ? 8'd0 :
                    (sum > 11'(twp_pkg::POSITION_MAX)) ? twp_pkg::POSITION_MAX : sum[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= v_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff <= pos_in;
         pv_ff  <= ok_ff[NDIV];
      end
   end

   assign out_valid          = valid_ff;
   assign out_position       = pos_ff;
   assign out_position_valid = pv_ff;

endmodule

/* src/twp_checker.sv */
`include "touch_wheel_position_defines.svh"

module twp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   // A result beat that is not taken stays offered with the same contents.
   `TWP_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // A scan without a valid touch always reports position zero.
   `TWP_ASSERT_IMP(a_invalid_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'd0)

   // Nothing is offered right after reset, since every stage was emptied.
   `TWP_ASSERT_RST_NXT(a_reset_empty, reset, !rsp_tvalid)

endmodule

bind touch_wheel_position twp_checker u_twp_checker (.*);

/* test/touch_wheel_checker.sv */
module touch_wheel_checker
   import twp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [63:0]         req_tdata,
   input  logic [0:0]          req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [7:0]          rsp_tdata,
   input  logic [0:0]          rsp_tuser,
   input  logic                csr_we,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [DATA_W-1:0]   csr_wdata,
   output int                  pending,
   output int                  mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] position;
      logic       valid;
   } wheel_result_type;

   twp_cfg_type      wheel_cfg;
   wheel_result_type expected_positions[$];

   function automatic twp_cfg_type reset_config();
      twp_cfg_type c;
      c.threshold   = '0;
      c.min_diff    = MIN_DIFF_RESET;
      c.resolution  = RESOLUTION_RESET;
      c.trim_offset = TRIM_OFFSET_RESET;
      c.sector_step = SECTOR_STEP_RESET;
      return c;
   endfunction

   // Finds the finger position for one scan under the given settings.
   function automatic wheel_result_type locate_touch(input twp_cfg_type c,
                                                     input logic [63:0] counts,
                                                     input logic touched);
      int unsigned      diff [NUM_CH];
      int unsigned      th, cnt, peak_diff, num, den, seg, quot, pos, mult, trim;
      int               peak;
      wheel_result_type r;
      r = '0;
      for (int k = 0; k < NUM_CH; k++) begin
         th      = c.threshold[k];
         cnt     = counts[16*k +: 16];
         diff[k] = (cnt < th) ? th - cnt : 0;
      end
      // Strictly greater only, so the lowest electrode wins a tie.
      peak      = 0;
      peak_diff = diff[0];
      for (int k = 1; k < NUM_CH; k++) begin
         if (diff[k] > peak_diff) begin
            peak_diff = diff[k];
            peak      = k;
         end
      end
      if (!touched || peak_diff < c.min_diff) begin
         return r;
      end
      case (peak)
         0: begin
            if (diff[1] > diff[3]) begin
               num = diff[1]; den = diff[0] + diff[1]; seg = 0;
            end else begin
               num = diff[0]; den = diff[3] + diff[0]; seg = 3;
            end
         end
         3: begin
            if (diff[2] > diff[0]) begin
               num = diff[3]; den = diff[2] + diff[3]; seg = 2;
            end else begin
               num = diff[0]; den = diff[3] + diff[0]; seg = 3;
            end
         end
         default: begin
            if (diff[peak-1] > diff[peak+1]) begin
               num = diff[peak]; den = diff[peak-1] + diff[peak]; seg = peak - 1;
            end else begin
               num = diff[peak+1]; den = diff[peak] + diff[peak+1]; seg = peak;
            end
         end
      endcase
      mult = int'(c.resolution) + 1;
      quot = (den == 0) ? 0 : (mult * num) / den;
      trim = c.trim_offset;
      quot = (quot >= trim) ? quot - trim : 0;
      pos  = quot + int'(c.sector_step) * seg;
      if (pos > 255) begin
         pos = 255;
      end
      r.position = pos[7:0];
      r.valid    = 1'b1;
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t checker: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      wheel_result_type oldest;
      if (reset) begin
         wheel_cfg = reset_config();
         expected_positions.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_positions.size() == 0) begin
               flag_mismatch($sformatf("result beat with nothing expected: position %0d valid %0d",
                                       rsp_tdata, rsp_tuser[0]));
            end else begin
               oldest = expected_positions.pop_front();
               if (rsp_tuser[0] !== oldest.valid) begin
                  flag_mismatch($sformatf("position_valid %0b, expected %0b",
                                          rsp_tuser[0], oldest.valid));
               end
               if (rsp_tdata !== oldest.position) begin
                  flag_mismatch($sformatf("position %0d, expected %0d",
                                          rsp_tdata, oldest.position));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_positions.push_back(locate_touch(wheel_cfg, req_tdata, req_tuser[0]));
         end
         if (csr_we) begin
            case (csr_index)
               REG_THRESHOLD_CH0: wheel_cfg.threshold[0] = csr_wdata;
               REG_THRESHOLD_CH1: wheel_cfg.threshold[1] = csr_wdata;
               REG_THRESHOLD_CH2: wheel_cfg.threshold[2] = csr_wdata;
               REG_THRESHOLD_CH3: wheel_cfg.threshold[3] = csr_wdata;
               REG_MIN_DIFF:      wheel_cfg.min_diff     = csr_wdata;
               REG_RESOLUTION:    wheel_cfg.resolution   = csr_wdata[7:0];
               REG_TRIM_OFFSET:   wheel_cfg.trim_offset  = csr_wdata[7:0];
               REG_SECTOR_STEP:   wheel_cfg.sector_step  = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      pending = expected_positions.size();
   end

endmodule

/* test/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import twp_pkg::*;

   // Extra wait after the last scan is answered, before touching the registers
   // or giving the verdict.
   localparam int DRAIN_CYCLES = 20;
   // Length of the one long receiver hold-off that fills the block up.
   localparam int HOLD_CYCLES  = 80;
   // Hard stop for a hung run, far beyond the slowest correct run.
   localparam int RUN_LIMIT_NS = 400000;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [63:0]        req_tdata  = '0;
   logic [0:0]         req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               csr_we     = 1'b0;
   logic [IDX_W-1:0]   csr_index  = REG_THRESHOLD_CH0;
   logic [DATA_W-1:0]  csr_wdata  = '0;

   int                 pending;
   int                 mismatches;

   // Idling knobs: percent of cycles in which the sender holds back a beat
   // and in which the receiver stalls.
   int                 sender_idle_pct = 0;
   int                 rsp_stall_pct   = 0;

   // The stimulus asks for a hold-off by bumping hold_asked; the receiver
   // process notices the change and counts the stall out by itself.
   int                 hold_asked  = 0;
   int                 hold_served = 0;
   int                 hold_left   = 0;

   // Settings last written, used to aim the scan counts at the thresholds.
   twp_cfg_type        cur_cfg;

   always #1 clock = ~clock;

   touch_wheel_position i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   touch_wheel_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .mismatches (mismatches)
   );

   // Receiver side. A requested hold-off keeps tready low while hold_left
   // counts down from HOLD_CYCLES; else tready stalls at random at the current rate.
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: a run that hangs is a failed run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

   // Drops the request and waits until every scan has been answered, then
   // lets the pipeline run empty before anything else happens. The first
   // edge gives the checker time to count a beat taken at the current edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_we after the last one so the
   // enable is never dropped and raised in the same step.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all eight registers while the block is idle.
   task automatic load_config(input twp_cfg_type c);
      wait_drained();
      write_reg(REG_THRESHOLD_CH0, c.threshold[0]);
      write_reg(REG_THRESHOLD_CH1, c.threshold[1]);
      write_reg(REG_THRESHOLD_CH2, c.threshold[2]);
      write_reg(REG_THRESHOLD_CH3, c.threshold[3]);
      write_reg(REG_MIN_DIFF, c.min_diff);
      write_reg(REG_RESOLUTION, {8'd0, c.resolution});
      write_reg(REG_TRIM_OFFSET, {8'd0, c.trim_offset});
      write_reg(REG_SECTOR_STEP, {8'd0, c.sector_step});
      csr_we  <= 1'b0;
      cur_cfg  = c;
   endtask

   // Idling modes: 0 none, 1 sender only, 2 receiver only, 3 both.
   task automatic set_idling(input int mode);
      case (mode)
         1: begin sender_idle_pct = 47; rsp_stall_pct <= 0;  end
         2: begin sender_idle_pct = 0;  rsp_stall_pct <= 47; end
         3: begin sender_idle_pct = 31; rsp_stall_pct <= 31; end
         default: begin sender_idle_pct = 0; rsp_stall_pct <= 0; end
      endcase
   endtask

   // Offers one scan beat and returns at the edge where it is taken. The
   // valid stays high afterward so back-to-back beats need no extra edge.
   task automatic send_scan(input logic [63:0] counts, input logic touched);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= counts;
      req_tuser  <= touched;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   task automatic send_counts(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2, input logic [15:0] c3,
                              input logic touched);
      send_scan({c3, c2, c1, c0}, touched);
   endtask

   // Random settings that hit the register extremes now and then.
   function automatic twp_cfg_type random_config();
      twp_cfg_type c;
      for (int k = 0; k < NUM_CH; k++) begin
         case ($urandom_range(7))
            0:       c.threshold[k] = 16'd0;
            1:       c.threshold[k] = 16'hffff;
            default: c.threshold[k] = 16'($urandom_range(65535, 100));
         endcase
      end
      case ($urandom_range(15))
         0, 1:    c.min_diff = 16'd0;
         2:       c.min_diff = 16'hffff;
         default: c.min_diff = 16'($urandom_range(3000));
      endcase
      case ($urandom_range(7))
         0:       c.resolution = 8'd1;
         1:       c.resolution = 8'd255;
         default: c.resolution = 8'($urandom_range(255, 1));
      endcase
      case ($urandom_range(7))
         0:       c.trim_offset = 8'd0;
         1:       c.trim_offset = 8'd255;
         default: c.trim_offset = 8'($urandom_range(60));
      endcase
      case ($urandom_range(7))
         0:       c.sector_step = 8'd0;
         1:       c.sector_step = 8'd255;
         default: c.sector_step = 8'($urandom_range(100));
      endcase
      return c;
   endfunction

   // Most scans look like a real finger: counts sit at, above or below each
   // threshold, usually a little below so that neighbors compete. The rest
   // are raw noise over the whole count range.
   task automatic send_random_scan();
      logic [63:0] counts;
      logic        touched;
      int unsigned th;
      if ($urandom_range(99) < 20) begin
         counts  = {$urandom, $urandom};
         touched = 1'($urandom_range(1));
      end else begin
         touched = ($urandom_range(9) != 0);
         for (int k = 0; k < NUM_CH; k++) begin
            th = cur_cfg.threshold[k];
            case ($urandom_range(3))
               0:       counts[16*k +: 16] = 16'(th + $urandom_range(65535 - th));
               1:       counts[16*k +: 16] = 16'(th - $urandom_range(th));
               default: counts[16*k +: 16] = 16'(th - $urandom_range((th < 3000) ? th : 3000));
            endcase
         end
         // Equal counts now and then to exercise the tie rules.
         if ($urandom_range(15) == 0) begin
            counts[47:32] = counts[15:0];
         end
      end
      send_scan(counts, touched);
   endtask

   initial begin
      twp_cfg_type c;

      cur_cfg.threshold   = '0;
      cur_cfg.min_diff    = MIN_DIFF_RESET;
      cur_cfg.resolution  = RESOLUTION_RESET;
      cur_cfg.trim_offset = TRIM_OFFSET_RESET;
      cur_cfg.sector_step = SECTOR_STEP_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset thresholds of zero every diff is zero, so both scans
      // fall below the default minimum and report no position.
      set_idling(0);
      send_counts(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send_counts(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);

      // Directed scans around a threshold of 1000 on every electrode; diff is
      // 1000 minus the count.
      c.threshold   = {4{16'd1000}};
      c.min_diff    = 16'd50;
      c.resolution  = 8'd90;
      c.trim_offset = 8'd12;
      c.sector_step = 8'd64;
      load_config(c);
      send_counts(16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b1); // all diffs zero
      send_counts(16'd400, 16'd1000, 16'd1000, 16'd1000, 1'b0);  // no touch flag
      // Peak on each electrode, with each neighbor taking the segment.
      send_counts(16'd200, 16'd600, 16'd1000, 16'd900, 1'b1);
      send_counts(16'd200, 16'd900, 16'd1000, 16'd600, 1'b1);
      send_counts(16'd600, 16'd200, 16'd900, 16'd1000, 1'b1);
      send_counts(16'd900, 16'd200, 16'd600, 16'd1000, 1'b1);
      send_counts(16'd1000, 16'd600, 16'd200, 16'd900, 1'b1);
      send_counts(16'd1000, 16'd900, 16'd200, 16'd600, 1'b1);
      send_counts(16'd900, 16'd1000, 16'd600, 16'd200, 1'b1);
      send_counts(16'd600, 16'd1000, 16'd900, 16'd200, 1'b1);
      // Ties: the lowest electrode must win the peak.
      send_counts(16'd500, 16'd500, 16'd500, 16'd500, 1'b1);
      send_counts(16'd1000, 16'd300, 16'd300, 16'd1000, 1'b1);
      // Peak just under and exactly at the minimum diff, then a tie of electrodes 0 and 2.
      send_counts(16'd960, 16'd970, 16'd980, 16'd990, 1'b1);
      send_counts(16'd950, 16'd1000, 16'd1000, 16'd1000, 1'b1);
      send_counts(16'd0, 16'hffff, 16'd0, 16'hffff, 1'b1);

      // Full-scale thresholds with no minimum: an all-zero diff scan gives a
      // zero denominator, and all-zero counts need the full 17-bit sum.
      c.threshold   = {4{16'hffff}};
      c.min_diff    = 16'd0;
      c.resolution  = 8'd255;
      c.trim_offset = 8'd0;
      c.sector_step = 8'd255;
      load_config(c);
      send_counts(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      send_counts(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send_counts(16'd0, 16'hfffe, 16'hffff, 16'hffff, 1'b1);
      send_counts(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);

      // The other extremes: largest minimum, smallest resolution, largest
      // trim and no sector step, so the trim floor clamps to zero.
      c.min_diff    = 16'hffff;
      c.resolution  = 8'd1;
      c.trim_offset = 8'd255;
      c.sector_step = 8'd0;
      load_config(c);
      send_counts(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      send_counts(16'd1, 16'd0, 16'd0, 16'd0, 1'b1);
      send_counts(16'd0, 16'd5, 16'd0, 16'd5, 1'b1);
      send_counts(16'd1, 16'd1, 16'd1, 16'd1, 1'b1);

      // Backpressure: the receiver holds off for a long stretch while the
      // sender keeps offering beats, so the block fills and drops req_tready.
      load_config(random_config());
      set_idling(0);
      hold_asked <= hold_asked + 1;
      repeat (40) send_random_scan();
      // The sender now pauses until every expected result is back.
      wait_drained();

      // Random phases, each with fresh settings and its own idling mode.
      for (int phase = 0; phase < 8; phase++) begin
         load_config(random_config());
         set_idling(phase % 4);
         repeat (100) send_random_scan();
      end

      set_idling(0);
      wait_drained();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
